>>> rtl/led_color_frame_crc8_packer_top_defines.svh
// Assertion macros used by the LED frame packer back end.
`ifndef LED_COLOR_FRAME_CRC8_PACKER_TOP_DEFINES_SVH
`define LED_COLOR_FRAME_CRC8_PACKER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, masked during reset.
`define LCFP_ASSERT_IMPL(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, masked during reset.
`define LCFP_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> rtl/lcfp_pkg.sv
// Types, codes and CRC helper for the LED colour frame packer.
package lcfp_pkg;

	localparam int CNT_W  = 4;
	localparam int BYTE_W = 8;
	localparam int POS_W  = 6;
	localparam int QDEPTH = 2;

	localparam logic [1:0] CMD_SET_ONE = 2'd0;
	localparam logic [1:0] CMD_SET_ALL = 2'd1;
	localparam logic [1:0] CMD_EMIT    = 2'd2;

	localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;
	localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;
	localparam logic [CNT_W-1:0]  LED_COUNT_RST = 4'd12;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [CNT_W-1:0]  led_index;
		logic [BYTE_W-1:0] red_value;
		logic [BYTE_W-1:0] green_value;
		logic [BYTE_W-1:0] blue_value;
	} req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] frame_byte;
		logic              block_select;
		logic              block_end;
		logic              frame_end;
	} rsp_t;

	// MSB-first CRC-8 over one byte
	function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
		input logic [BYTE_W-1:0] data);
		logic [BYTE_W-1:0] c;
		c = crc;
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			if (data[i] ^ c[BYTE_W-1]) begin
				c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[BYTE_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> rtl/lcfp_front.sv
// Front end: accepts requests and drops those that have no effect.
module lcfp_front
	import lcfp_pkg::*;
(
	input  logic             req_valid,
	output logic             req_ready,
	input  req_t             req,
	input  logic [CNT_W-1:0] leds_in_use,
	input  logic             q_full,
	output logic             q_push,
	output req_t             q_data
);

	logic keep;

	always_comb begin
		case (req.cmd)
			CMD_SET_ONE: keep = req.led_index < leds_in_use;
			CMD_SET_ALL: keep = 1'b1;
			CMD_EMIT:    keep = 1'b1;
			default:     keep = 1'b0;
		endcase
	end

	assign req_ready = !q_full;
	assign q_push    = req_valid && !q_full && keep;
	assign q_data    = req;

endmodule

>>> rtl/lcfp_fifo.sv
// Two-entry command queue between front and back end.
module lcfp_fifo
	import lcfp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  req_t push_data,
	output logic full,
	output logic pop_valid,
	input  logic pop,
	output req_t pop_data
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	req_t          entry_q [QDEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full      = cnt_q == CW'(QDEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_data  = entry_q[rp_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (int'(wp_q) == QDEPTH - 1) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (int'(rp_q) == QDEPTH - 1) ? '0 : rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wp_q] <= push_data;
		end
	end

endmodule

>>> rtl/lcfp_back.sv
// Back end: colour store, set-all sweep and frame/CRC streaming.
`include "led_color_frame_crc8_packer_top_defines.svh"
module lcfp_back
	import lcfp_pkg::*;
#(
	parameter int MAX_LEDS    = 12,
	parameter int BLOCK_BYTES = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data,
	output logic [CNT_W-1:0] leds_in_use,
	input  logic             q_valid,
	output logic             q_pop,
	input  req_t             q_data,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_t             rsp
);

	localparam int LW    = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
	localparam int ROW_W = 3 * BYTE_W;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SWEEP = 2'd1;
	localparam logic [1:0] ST_EMIT  = 2'd2;

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  n;
	logic [POS_W-1:0]  total;
	logic              split;
	logic [LW-1:0]     led_q;
	logic [LW-1:0]     led_d;
	logic [LW-1:0]     sw_q;
	logic [1:0]        comp_q;
	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] crc_q;
	logic [ROW_W-1:0]  mem [MAX_LEDS];
	logic [ROW_W-1:0]  rd_q;
	logic              rdv_q;
	logic [MAX_LEDS-1:0] valid_q;
	logic [ROW_W-1:0]  sweep_rgb_q;
	logic              we;
	logic [LW-1:0]     wa;
	logic [ROW_W-1:0]  wd;
	logic [ROW_W-1:0]  row;
	logic [BYTE_W-1:0] cur_byte;
	logic              last;
	logic              adv;
	logic              blk;
	logic              bend;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	assign cfg_ready   = 1'b1;
	assign n           = (int'(count_q) > MAX_LEDS) ? CNT_W'(MAX_LEDS) : count_q;
	assign leds_in_use = n;
	assign total       = POS_W'({n, 1'b0}) + POS_W'(n) + POS_W'(2);
	assign split       = total > POS_W'(BLOCK_BYTES);
	assign last        = pos_q == total - 1'b1;
	assign adv         = !rsp_valid_q || rsp_ready;
	assign q_pop       = q_valid && (state_q == ST_IDLE);
	assign blk         = split && (pos_q >= POS_W'(BLOCK_BYTES));
	assign bend        = last || (split && (pos_q == POS_W'(BLOCK_BYTES - 1)));
	assign row         = rdv_q ? rd_q : '0;

	always_comb begin
		if (pos_q == '0) begin
			cur_byte = BYTE_W'(n);
		end else if (last) begin
			cur_byte = crc_q;
		end else begin
			case (comp_q)
				2'd0:    cur_byte = row[ROW_W-1 -: BYTE_W];
				2'd1:    cur_byte = row[BYTE_W +: BYTE_W];
				default: cur_byte = row[BYTE_W-1:0];
			endcase
		end
	end

	// store write port
	always_comb begin
		we = 1'b0;
		wa = sw_q;
		wd = sweep_rgb_q;
		if (state_q == ST_SWEEP) begin
			we = 1'b1;
		end else if (q_pop && (q_data.cmd == CMD_SET_ONE)) begin
			we = 1'b1;
			wa = LW'(q_data.led_index);
			wd = {q_data.red_value, q_data.green_value, q_data.blue_value};
		end
	end

	// read address leads led_q so rd_q always holds the current LED's row
	always_comb begin
		led_d = led_q;
		if (q_pop && (q_data.cmd == CMD_EMIT)) begin
			led_d = '0;
		end else if ((state_q == ST_EMIT) && adv && !last && (pos_q != '0) &&
				(comp_q == 2'd2) && (int'(led_q) + 1 < int'(n))) begin
			led_d = led_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= LED_COUNT_RST;
			valid_q     <= '0;
			rsp_valid_q <= 1'b0;
			led_q       <= '0;
			sw_q        <= '0;
			comp_q      <= '0;
			pos_q       <= '0;
			crc_q       <= CRC_INIT;
		end else begin
			led_q <= led_d;
			if (cfg_valid) begin
				count_q <= cfg_data;
			end
			if (we) begin
				valid_q[wa] <= 1'b1;
			end
			if (rsp_valid_q && rsp_ready && !((state_q == ST_EMIT) && adv)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						case (q_data.cmd)
							CMD_SET_ALL: begin
								if (n != '0) begin
									state_q <= ST_SWEEP;
									sw_q    <= '0;
								end
							end
							CMD_EMIT: begin
								state_q <= ST_EMIT;
								pos_q   <= '0;
								comp_q  <= '0;
								crc_q   <= CRC_INIT;
							end
							default: ;
						endcase
					end
				end
				ST_SWEEP: begin
					if (int'(sw_q) + 1 >= int'(n)) begin
						state_q <= ST_IDLE;
					end else begin
						sw_q <= sw_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (adv) begin
						rsp_valid_q <= 1'b1;
						pos_q       <= pos_q + 1'b1;
						if (!last) begin
							crc_q <= crc8_byte(crc_q, cur_byte);
						end
						if (!last && (pos_q != '0)) begin
							comp_q <= (comp_q == 2'd2) ? 2'd0 : comp_q + 1'b1;
						end
						if (last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			sweep_rgb_q <= {q_data.red_value, q_data.green_value, q_data.blue_value};
		end
		if ((state_q == ST_EMIT) && adv) begin
			rsp_q <= '{frame_byte: cur_byte, block_select: blk, block_end: bend,
				frame_end: last};
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q  <= mem[led_d];
		rdv_q <= valid_q[led_d];
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`LCFP_ASSERT_IMPL(a_emit_pos, state_q == ST_EMIT, pos_q < total, "frame position overrun")
	`LCFP_ASSERT_IMPL(a_sweep_idx, state_q == ST_SWEEP, int'(sw_q) < int'(n), "sweep overrun")
	`LCFP_ASSERT_IMPL(a_no_wr_emit, state_q == ST_EMIT, !we, "store written mid-frame")
	`LCFP_ASSERT_NEXT(a_frame_close, (state_q == ST_EMIT) && adv && last,
		(state_q == ST_IDLE) && rsp_valid_q && rsp_q.frame_end, "frame not closed")

endmodule

>>> rtl/led_color_frame_crc8_packer_top.sv
// Top level of the LED colour frame packer with CRC-8.
//
// channel  dir  payload            transfer when
// req      in   req_t              req_valid & req_ready
// rsp      out  rsp_t              rsp_valid & rsp_ready
// cfg      in   led_count (4 bit)  cfg_valid & cfg_ready (always ready)
//
// Set one: written to the store as it is dequeued. Set all: one store row per cycle,
// leds_in_use rows in all. Emit: 3*leds_in_use+2 bytes,
// one per cycle from the output register; rsp stalls hold the stream.
// A two-entry queue lets requests be taken while a frame is streaming.
// Reset clears the store through per-LED valid bits: no clearing pass.
module led_color_frame_crc8_packer_top
	import lcfp_pkg::*;
#(
	parameter int MAX_LEDS    = 12,
	parameter int BLOCK_BYTES = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_t             rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data
);

	logic             q_full;
	logic             q_push;
	req_t             q_in;
	logic             q_valid;
	logic             q_pop;
	req_t             q_out;
	logic [CNT_W-1:0] leds_in_use;

	lcfp_front u_front (
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.leds_in_use (leds_in_use),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_in)
	);

	lcfp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop_valid (q_valid),
		.pop       (q_pop),
		.pop_data  (q_out)
	);

	lcfp_back #(
		.MAX_LEDS    (MAX_LEDS),
		.BLOCK_BYTES (BLOCK_BYTES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.leds_in_use (leds_in_use),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_data      (q_out),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp)
	);

endmodule
